// ----- rtl/jhgr_pkg.sv -----
// ----------------------------------------------------------------------------
// jhgr_pkg
// Shared types and constants for the Jacobi heat grid relaxation block:
// grid geometry, register map, command codes and the structs that pass
// between the top level and the relaxation engine.
// ----------------------------------------------------------------------------
package jhgr_pkg;

    // Grid geometry: interior cells per side, plus one border cell on each side.
    localparam int MAX_INTERIOR = 62;
    localparam int SIDE         = MAX_INTERIOR + 2;
    localparam int COORD_W      = $clog2(SIDE);
    localparam int ADDR_W       = 2 * COORD_W;
    localparam int DEPTH        = 1 << ADDR_W;

    // Field widths fixed by the interface.
    localparam int TEMP_W  = 32;
    localparam int SIZE_W  = 6;
    localparam int ITER_W  = 16;
    localparam int POS_W   = 6;
    localparam int ACC_W   = TEMP_W + 2;

    // Configuration port.
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_TEMP   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOP_TEMP    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_TEMP  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM_TEMP = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DELTA   = 3'd6;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET  = 6'd62;
    localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 16'd1;

    // Command codes.
    localparam logic OP_RUN  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration registers as seen by the engine.
    typedef struct packed {
        logic [SIZE_W-1:0] grid_size;
        logic [TEMP_W-1:0] left_temp;
        logic [TEMP_W-1:0] top_temp;
        logic [TEMP_W-1:0] right_temp;
        logic [TEMP_W-1:0] bottom_temp;
        logic [ITER_W-1:0] iteration_limit;
        logic [TEMP_W-1:0] max_delta;
    } t_cfg;

    // One command word.
    typedef struct packed {
        logic             opcode;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
    } t_cmd;

    // One result word with its strobe.
    typedef struct packed {
        logic              valid;
        logic [TEMP_W-1:0] cell_value;
        logic [ITER_W-1:0] iterations_done;
        logic              converged;
    } t_result;

endpackage

// ----- rtl/jhgr_engine.sv -----
// ----------------------------------------------------------------------------
// jhgr_engine
// Sequencer, grid buffers and the shared accumulate unit. A run builds the
// borders, then sweeps the interior cell by cell: four reads of the source
// buffer feed one accumulator, a fifth reads the center, the quarter sum goes
// to the other buffer and the change is folded into the sweep's largest change.
// ----------------------------------------------------------------------------
module jhgr_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jhgr_pkg::t_cfg   i_cfg,
    input  logic             i_start,
    input  jhgr_pkg::t_cmd   i_cmd,
    output logic             o_busy,
    output jhgr_pkg::t_result o_result
);

    localparam int CW = jhgr_pkg::COORD_W;
    localparam int TW = jhgr_pkg::TEMP_W;
    localparam int AW = jhgr_pkg::ADDR_W;
    localparam int IW = jhgr_pkg::ITER_W;
    localparam int XW = jhgr_pkg::ACC_W;

    // Phases of one cell: read up, down, left, right, center, then write.
    localparam logic [2:0] PH_UP     = 3'd0;
    localparam logic [2:0] PH_DOWN   = 3'd1;
    localparam logic [2:0] PH_LEFT   = 3'd2;
    localparam logic [2:0] PH_RIGHT  = 3'd3;
    localparam logic [2:0] PH_CENTER = 3'd4;
    localparam logic [2:0] PH_WRITE  = 3'd5;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_BUILD    = 7'b0000010,
        S_SWEEP    = 7'b0000100,
        S_FOLD     = 7'b0001000,
        S_CHECK    = 7'b0010000,
        S_READ     = 7'b0100000,
        S_READ_OUT = 7'b1000000
    } t_state;

    t_state          r_state;
    t_state          n_state;

    // Control state.
    logic [CW-1:0]   r_run_n;
    logic [IW-1:0]   r_count;
    logic            r_conv;
    logic            r_latest;
    logic            r_diff_vld;
    logic            r_valid;

    // Datapath state.
    logic [CW-1:0]   r_row;
    logic [CW-1:0]   r_col;
    logic [2:0]      r_ph;
    logic [XW-1:0]   r_acc;
    logic [TW-1:0]   r_diff;
    logic [TW-1:0]   r_big;
    logic [CW-1:0]   r_rd_row;
    logic [CW-1:0]   r_rd_col;
    logic            r_rd_ok;
    logic [TW-1:0]   r_cell;
    logic [IW-1:0]   r_iter;
    logic            r_conv_o;

    // Grid buffers.
    logic [TW-1:0]   mem_even [0:jhgr_pkg::DEPTH-1];
    logic [TW-1:0]   mem_odd  [0:jhgr_pkg::DEPTH-1];
    logic [TW-1:0]   r_q_even;
    logic [TW-1:0]   r_q_odd;

    logic            accept;
    logic [CW-1:0]   n_clamp;
    logic [CW-1:0]   last;
    logic [IW-1:0]   limit_eff;
    logic [IW-1:0]   count_inc;
    logic            build_end;
    logic            row_end;
    logic            sweep_end;
    logic            below;
    logic            stop;
    logic            rd_ok;
    logic [TW-1:0]   rdata;
    logic [TW-1:0]   border_val;
    logic [TW-1:0]   new_val;
    logic [TW-1:0]   new_diff;
    logic [CW-1:0]   ra_row;
    logic [CW-1:0]   ra_col;
    logic [AW-1:0]   raddr;
    logic [AW-1:0]   waddr;
    logic [TW-1:0]   wdata;
    logic            we_even;
    logic            we_odd;

    // Command acceptance and run parameters.
    assign accept    = i_start && (r_state == S_IDLE);
    assign o_busy    = (r_state != S_IDLE);
    assign limit_eff = (i_cfg.iteration_limit == '0) ? IW'(1) : i_cfg.iteration_limit;
    assign count_inc = r_count + IW'(1);
    assign last      = r_run_n + CW'(1);

    always_comb begin
        if (i_cfg.grid_size == '0) begin
            n_clamp = CW'(1);
        end else if (int'(i_cfg.grid_size) > jhgr_pkg::MAX_INTERIOR) begin
            n_clamp = CW'(jhgr_pkg::MAX_INTERIOR);
        end else begin
            n_clamp = CW'(i_cfg.grid_size);
        end
    end

    // A read inside the latest grid returns the stored cell, else zero.
    assign rd_ok = (r_run_n != '0)
                && (8'(i_cmd.row) <= 8'(last))
                && (8'(i_cmd.column) <= 8'(last));

    // The source buffer of a sweep is the one written last.
    assign rdata = r_latest ? r_q_odd : r_q_even;

    assign build_end = (r_row == last) && (r_col == last);
    assign row_end   = (r_col == r_run_n);
    assign sweep_end = (r_ph == PH_WRITE) && row_end && (r_row == r_run_n);
    assign below     = (r_big < i_cfg.max_delta);
    assign stop      = below || (count_inc == limit_eff);

    // Border pattern: columns overwrite rows at the corners.
    always_comb begin
        priority if (r_col == last) begin
            border_val = i_cfg.right_temp;
        end else if (r_col == '0) begin
            border_val = i_cfg.left_temp;
        end else if (r_row == '0) begin
            border_val = i_cfg.top_temp;
        end else if (r_row == last) begin
            border_val = i_cfg.bottom_temp;
        end else begin
            border_val = '0;
        end
    end

    // New cell value and its absolute change against the old value.
    assign new_val  = r_acc[XW-1:2];
    assign new_diff = (new_val >= rdata) ? (new_val - rdata) : (rdata - new_val);

    // Read address: one stencil neighbor per phase, or the cell of a read command.
    always_comb begin
        ra_row = r_row;
        ra_col = r_col;
        if (r_state == S_READ) begin
            ra_row = r_rd_row;
            ra_col = r_rd_col;
        end else begin
            unique case (r_ph)
                PH_UP:    ra_row = r_row - CW'(1);
                PH_DOWN:  ra_row = r_row + CW'(1);
                PH_LEFT:  ra_col = r_col - CW'(1);
                PH_RIGHT: ra_col = r_col + CW'(1);
                default: begin
                    ra_row = r_row;
                    ra_col = r_col;
                end
            endcase
        end
    end
    assign raddr = {ra_row, ra_col};

    // Write port: borders into both buffers, sweep results into the other one.
    always_comb begin
        waddr   = {r_row, r_col};
        wdata   = new_val;
        we_even = 1'b0;
        we_odd  = 1'b0;
        if (r_state == S_BUILD) begin
            wdata   = border_val;
            we_even = 1'b1;
            we_odd  = 1'b1;
        end else if ((r_state == S_SWEEP) && (r_ph == PH_WRITE)) begin
            we_even = r_latest;
            we_odd  = !r_latest;
        end
    end

    // Grid buffer memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (we_even) begin
            mem_even[waddr] <= wdata;
        end
        r_q_even <= mem_even[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_odd) begin
            mem_odd[waddr] <= wdata;
        end
        r_q_odd <= mem_odd[raddr];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_cmd.opcode == jhgr_pkg::OP_RUN) ? S_BUILD : S_READ;
                end
            end
            S_BUILD: begin
                if (build_end) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (sweep_end) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD:     n_state = S_CHECK;
            S_CHECK:    n_state = stop ? S_IDLE : S_SWEEP;
            S_READ:     n_state = S_READ_OUT;
            S_READ_OUT: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_run_n    <= '0;
            r_count    <= '0;
            r_conv     <= 1'b0;
            r_latest   <= 1'b0;
            r_diff_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= 1'b0;
            r_diff_vld <= (r_state == S_SWEEP) && (r_ph == PH_WRITE);
            if (accept && (i_cmd.opcode == jhgr_pkg::OP_RUN)) begin
                r_run_n  <= n_clamp;
                r_count  <= '0;
                r_conv   <= 1'b0;
                r_latest <= 1'b0;
            end
            if (r_state == S_CHECK) begin
                r_count  <= count_inc;
                r_latest <= !r_latest;
                r_conv   <= below;
                r_valid  <= stop;
            end
            if (r_state == S_READ_OUT) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Datapath registers: counters, accumulator, largest change, result word.
    always_ff @(posedge i_clk) begin
        if (r_diff_vld && (r_diff > r_big)) begin
            r_big <= r_diff;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_row    <= '0;
                    r_col    <= '0;
                    r_rd_row <= CW'(i_cmd.row);
                    r_rd_col <= CW'(i_cmd.column);
                    r_rd_ok  <= rd_ok;
                end
            end
            S_BUILD: begin
                if (build_end) begin
                    r_row <= CW'(1);
                    r_col <= CW'(1);
                    r_ph  <= PH_UP;
                    r_big <= '0;
                end else if (r_col == last) begin
                    r_col <= '0;
                    r_row <= r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            S_SWEEP: begin
                unique case (r_ph)
                    PH_DOWN: r_acc <= {2'b00, rdata};
                    PH_LEFT, PH_RIGHT, PH_CENTER: r_acc <= r_acc + {2'b00, rdata};
                    default: r_acc <= r_acc;
                endcase
                if (r_ph == PH_WRITE) begin
                    r_diff <= new_diff;
                    r_ph   <= PH_UP;
                    if (row_end) begin
                        r_col <= CW'(1);
                        r_row <= r_row + CW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end else begin
                    r_ph <= r_ph + 3'd1;
                end
            end
            S_FOLD: begin
                r_ph <= PH_UP;
            end
            S_CHECK: begin
                r_cell   <= '0;
                r_iter   <= count_inc;
                r_conv_o <= below;
                if (!stop) begin
                    r_row <= CW'(1);
                    r_col <= CW'(1);
                    r_ph  <= PH_UP;
                    r_big <= '0;
                end
            end
            S_READ: begin
                r_ph <= PH_UP;
            end
            S_READ_OUT: begin
                r_cell   <= r_rd_ok ? rdata : '0;
                r_iter   <= r_count;
                r_conv_o <= r_conv;
            end
            default: begin
                r_ph <= PH_UP;
            end
        endcase
    end

    assign o_result.valid           = r_valid;
    assign o_result.cell_value      = r_cell;
    assign o_result.iterations_done = r_iter;
    assign o_result.converged       = r_conv_o;

    // A sweep never writes the buffer that it reads.
    a_dst_not_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !(we_even && !r_latest) && !(we_odd && r_latest))
        else $error("sweep writes its source buffer");

    // The sweep position stays inside the interior.
    a_in_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_row >= CW'(1)) && (r_row <= r_run_n)
                              && (r_col >= CW'(1)) && (r_col <= r_run_n))
        else $error("sweep position outside the interior");

    // Sweeps in progress stay below the limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_count < limit_eff))
        else $error("sweep count reached the limit while sweeping");

    // A result word follows only the end of a run or of a read.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == S_CHECK) || ($past(r_state) == S_READ_OUT))
        else $error("result word without a finished command");

endmodule

// ----- rtl/jacobi_heat_grid_relaxation.sv -----
// ----------------------------------------------------------------------------
// jacobi_heat_grid_relaxation
// Read command: the strobe rises after the read and read-out states.
// Run command: the grid is built, then sweeps run over the interior, each one
// ended by a fold and a check state; the strobe comes from the final check.
// Busy stays high for the whole command; the strobe is high for one cycle.
// Synchronous reset clears the sequencer and loads the register defaults;
// the grid buffers are not cleared and are defined only after a run.
// ----------------------------------------------------------------------------
module jacobi_heat_grid_relaxation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jhgr_pkg::PADDR_W-1:0]    paddr,
    input  logic [jhgr_pkg::PDATA_W-1:0]    pwdata,
    output logic [jhgr_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // Command channel.
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [jhgr_pkg::POS_W-1:0]      i_row,
    input  logic [jhgr_pkg::POS_W-1:0]      i_column,
    // Result channel.
    output logic                            o_valid,
    output logic [jhgr_pkg::TEMP_W-1:0]     o_cell_value,
    output logic [jhgr_pkg::ITER_W-1:0]     o_iterations_done,
    output logic                            o_converged
);

    localparam int DW = jhgr_pkg::PDATA_W;

    jhgr_pkg::t_cfg                    r_cfg;
    jhgr_pkg::t_cmd                    cmd;
    jhgr_pkg::t_result                 result;
    logic [jhgr_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[jhgr_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size       <= jhgr_pkg::GRID_SIZE_RESET;
            r_cfg.left_temp       <= '0;
            r_cfg.top_temp        <= '0;
            r_cfg.right_temp      <= '0;
            r_cfg.bottom_temp     <= '0;
            r_cfg.iteration_limit <= jhgr_pkg::ITER_LIMIT_RESET;
            r_cfg.max_delta       <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                jhgr_pkg::REG_GRID_SIZE:   r_cfg.grid_size <= pwdata[jhgr_pkg::SIZE_W-1:0];
                jhgr_pkg::REG_LEFT_TEMP:   r_cfg.left_temp   <= pwdata;
                jhgr_pkg::REG_TOP_TEMP:    r_cfg.top_temp    <= pwdata;
                jhgr_pkg::REG_RIGHT_TEMP:  r_cfg.right_temp  <= pwdata;
                jhgr_pkg::REG_BOTTOM_TEMP: r_cfg.bottom_temp <= pwdata;
                jhgr_pkg::REG_ITER_LIMIT:
                    r_cfg.iteration_limit <= pwdata[jhgr_pkg::ITER_W-1:0];
                jhgr_pkg::REG_MAX_DELTA:   r_cfg.max_delta   <= pwdata;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            jhgr_pkg::REG_GRID_SIZE:   prdata = DW'(r_cfg.grid_size);
            jhgr_pkg::REG_LEFT_TEMP:   prdata = r_cfg.left_temp;
            jhgr_pkg::REG_TOP_TEMP:    prdata = r_cfg.top_temp;
            jhgr_pkg::REG_RIGHT_TEMP:  prdata = r_cfg.right_temp;
            jhgr_pkg::REG_BOTTOM_TEMP: prdata = r_cfg.bottom_temp;
            jhgr_pkg::REG_ITER_LIMIT:  prdata = DW'(r_cfg.iteration_limit);
            jhgr_pkg::REG_MAX_DELTA:   prdata = r_cfg.max_delta;
            default:                   prdata = '0;
        endcase
    end

    // Command word into the engine.
    assign cmd.opcode = i_opcode;
    assign cmd.row    = i_row;
    assign cmd.column = i_column;

    jhgr_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (start),
        .i_cmd    (cmd),
        .o_busy   (busy),
        .o_result (result)
    );

    // Result word out.
    assign o_valid           = result.valid;
    assign o_cell_value      = result.cell_value;
    assign o_iterations_done = result.iterations_done;
    assign o_converged       = result.converged;

endmodule

// ----- dv/tb_jacobi_heat_grid_relaxation.sv -----
// ----------------------------------------------------------------------------
// tb_jacobi_heat_grid_relaxation
// Self-checking testbench for the Jacobi heat grid relaxation block. A short
// table of directed commands covers reset defaults, size and limit clamping,
// border layout, reads outside the grid and threshold behavior. Random
// phases follow, each reprogramming the registers over APB and issuing a run
// followed by reads and runs. Each result word is checked against its table
// value or a behavioral model of grid, borders and sweeps in this testbench.
// ----------------------------------------------------------------------------
module tb_jacobi_heat_grid_relaxation;

    timeunit 1ns;
    timeprecision 1ps;

    import jhgr_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TAIL_CYCLES    = 16;
    localparam int RANDOM_ITEMS   = 115;

    localparam logic CHK_MODEL = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef enum logic {ACT_WRITE, ACT_CMD} t_step_kind;

    // One result word as the model sees it.
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [ITER_W-1:0] iters;
        logic              conv;
    } t_heat_word;

    // One row of the directed table: a register write or a command.
    typedef struct packed {
        t_step_kind           act;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [TEMP_W-1:0]    value;
        logic                 op;
        logic [POS_W-1:0]     row;
        logic [POS_W-1:0]     col;
        logic                 chk;
        t_heat_word           want;
    } t_step_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [POS_W-1:0]     i_row;
    logic [POS_W-1:0]     i_column;
    logic                 o_valid;
    logic [TEMP_W-1:0]    o_cell_value;
    logic [ITER_W-1:0]    o_iterations_done;
    logic                 o_converged;

    // Register mirror.
    logic [SIZE_W-1:0]    cfg_size  = GRID_SIZE_RESET;
    logic [TEMP_W-1:0]    cfg_left  = '0;
    logic [TEMP_W-1:0]    cfg_top   = '0;
    logic [TEMP_W-1:0]    cfg_right = '0;
    logic [TEMP_W-1:0]    cfg_bot   = '0;
    logic [ITER_W-1:0]    cfg_limit = ITER_LIMIT_RESET;
    logic [TEMP_W-1:0]    cfg_delta = '0;

    // Model state: two grid planes and the outcome of the latest run.
    logic [TEMP_W-1:0]    plate [0:1][0:SIDE*SIDE-1];
    logic                 plate_cur     = 1'b0;
    int                   run_n         = 0;
    logic [ITER_W-1:0]    sweeps_done   = '0;
    logic                 threshold_hit = 1'b0;

    t_heat_word           heat_words_due [$];
    t_step_row            dir_steps [$];
    t_heat_word           seen_want;
    int                   errors       = 0;
    int                   quiet_cycles = 0;

    jacobi_heat_grid_relaxation DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_row             (i_row),
        .i_column          (i_column),
        .o_valid           (o_valid),
        .o_cell_value      (o_cell_value),
        .o_iterations_done (o_iterations_done),
        .o_converged       (o_converged)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Model of one accepted command: a run builds and relaxes the grid, a read
    // returns one cell of the plane written last.
    task automatic relax_step(input logic op, input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] col, output t_heat_word w);
        int                unsigned n;
        int                unsigned lim;
        int                k;
        int                r;
        int                c;
        int                at;
        logic [ACC_W-1:0]  sum;
        logic [TEMP_W-1:0] v;
        logic [TEMP_W-1:0] old;
        logic [TEMP_W-1:0] d;
        logic [TEMP_W-1:0] big;
        logic [TEMP_W-1:0] border;
        w.temp = '0;
        if (op == OP_RUN) begin
            n = 32'(cfg_size);
            if (n == 0) n = 1;
            if (n > MAX_INTERIOR) n = MAX_INTERIOR;
            lim = (cfg_limit == '0) ? 1 : 32'(cfg_limit);
            // Both planes get zero interior, top and bottom rows, then the
            // side columns, which win at the corners.
            for (r = 0; r <= n + 1; r++) begin
                for (c = 0; c <= n + 1; c++) begin
                    border = '0;
                    if (r == 0) border = cfg_top;
                    if (r == n + 1) border = cfg_bot;
                    if (c == 0) border = cfg_left;
                    if (c == n + 1) border = cfg_right;
                    plate[0][r*SIDE+c] = border;
                    plate[1][r*SIDE+c] = border;
                end
            end
            run_n         = int'(n);
            threshold_hit = 1'b0;
            sweeps_done   = '0;
            plate_cur     = 1'b0;
            // Sweeps alternate planes and stop early once the largest change
            // drops below the threshold.
            for (k = 0; k < lim && !threshold_hit; k++) begin
                big = '0;
                for (r = 1; r <= n; r++) begin
                    for (c = 1; c <= n; c++) begin
                        at  = r * SIDE + c;
                        sum = plate[plate_cur][at-SIDE] + plate[plate_cur][at+SIDE] +
                              plate[plate_cur][at-1] + plate[plate_cur][at+1];
                        v   = sum[ACC_W-1:2];
                        old = plate[plate_cur][at];
                        d   = (v >= old) ? v - old : old - v;
                        plate[~plate_cur][at] = v;
                        if (d > big) big = d;
                    end
                end
                plate_cur   = ~plate_cur;
                sweeps_done = ITER_W'(k + 1);
                if (big < cfg_delta) threshold_hit = 1'b1;
            end
        end else if (run_n != 0 && int'(row) <= run_n + 1 && int'(col) <= run_n + 1) begin
            w.temp = plate[plate_cur][int'(row)*SIDE+int'(col)];
        end
        w.iters = sweeps_done;
        w.conv  = threshold_hit;
    endtask

    // Gap before the next command word: mostly none or short, a few long.
    function automatic int pick_gap(input logic no_idle);
        int sel;
        sel = int'($urandom_range(0, 99));
        if (no_idle) return 0;
        if (sel < 60) return 0;
        if (sel < 90) return int'($urandom_range(1, 3));
        if (sel < 98) return int'($urandom_range(4, 12));
        return int'($urandom_range(30, 150));
    endfunction

    function automatic t_step_row cfg_row(input logic [REG_IDX_W-1:0] idx,
                                          input logic [TEMP_W-1:0] value);
        t_step_row s;
        s         = '0;
        s.act     = ACT_WRITE;
        s.reg_idx = idx;
        s.value   = value;
        return s;
    endfunction

    function automatic t_step_row cmd_row(input logic op, input logic [POS_W-1:0] row,
                                          input logic [POS_W-1:0] col, input logic chk,
                                          input logic [TEMP_W-1:0] temp,
                                          input logic [ITER_W-1:0] iters,
                                          input logic conv);
        t_step_row s;
        s            = '0;
        s.act        = ACT_CMD;
        s.op         = op;
        s.row        = row;
        s.col        = col;
        s.chk        = chk;
        s.want.temp  = temp;
        s.want.iters = iters;
        s.want.conv  = conv;
        return s;
    endfunction

    // APB write: setup cycle, then access cycle; the mirror follows the edge.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_GRID_SIZE:   cfg_size  = value[SIZE_W-1:0];
            REG_LEFT_TEMP:   cfg_left  = value;
            REG_TOP_TEMP:    cfg_top   = value;
            REG_RIGHT_TEMP:  cfg_right = value;
            REG_BOTTOM_TEMP: cfg_bot   = value;
            REG_ITER_LIMIT:  cfg_limit = value[ITER_W-1:0];
            REG_MAX_DELTA:   cfg_delta = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Present one command word, wait for it to be taken, then idle for any gap.
    task automatic send_cmd(input logic op, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic chk,
                            input t_heat_word typed, input int gap);
        t_heat_word w;
        @(negedge i_clk);
        start    = 1'b1;
        i_opcode = op;
        i_row    = row;
        i_column = col;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        relax_step(op, row, col, w);
        heat_words_due.push_back((chk == CHK_TYPED) ? typed : w);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Let every outstanding word come back and the block go idle.
    task automatic drain_block();
        @(negedge i_clk);
        start = 1'b0;
        while (heat_words_due.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Result checker and activity counter for the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (heat_words_due.size() == 0) begin
                $error("result word with none expected: cell_value %h", o_cell_value);
                errors++;
            end else begin
                seen_want = heat_words_due.pop_front();
                if (o_cell_value !== seen_want.temp) begin
                    $error("cell_value: expected %h, actual %h", seen_want.temp, o_cell_value);
                    errors++;
                end
                if (o_iterations_done !== seen_want.iters) begin
                    $error("iterations_done: expected %0d, actual %0d",
                           seen_want.iters, o_iterations_done);
                    errors++;
                end
                if (o_converged !== seen_want.conv) begin
                    $error("converged: expected %b, actual %b", seen_want.conv, o_converged);
                    errors++;
                end
            end
        end
        if ((i_rst_n && start && !busy) || (i_rst_n && o_valid)) quiet_cycles = 0;
        else quiet_cycles++;
    end

    // Watchdog on a stalled block.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // Directed table.
    initial begin
        // Reset defaults: all-zero plate, one sweep, zero threshold.
        dir_steps.push_back(cmd_row(OP_RUN,  6'd0,  6'd0,  CHK_TYPED, 32'h0, 16'd1, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd63, 6'd63, CHK_TYPED, 32'h0, 16'd1, 1'b0));
        // Smallest grid, distinct borders, zero limit runs one sweep.
        dir_steps.push_back(cfg_row(REG_GRID_SIZE,   32'd1));
        dir_steps.push_back(cfg_row(REG_LEFT_TEMP,   32'h0001_0000));
        dir_steps.push_back(cfg_row(REG_TOP_TEMP,    32'hFFFF_FFFF));
        dir_steps.push_back(cfg_row(REG_RIGHT_TEMP,  32'h1234_5678));
        dir_steps.push_back(cfg_row(REG_BOTTOM_TEMP, 32'h0));
        dir_steps.push_back(cfg_row(REG_ITER_LIMIT,  32'd0));
        dir_steps.push_back(cfg_row(REG_MAX_DELTA,   32'd0));
        dir_steps.push_back(cmd_row(OP_RUN,  6'd0,  6'd0,  CHK_TYPED, 32'h0, 16'd1, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd1,  6'd1,  CHK_MODEL, 32'h0, 16'd0, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd0,  6'd1,  CHK_TYPED, 32'hFFFF_FFFF, 16'd1, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd0,  6'd0,  CHK_TYPED, 32'h0001_0000, 16'd1, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd2,  6'd2,  CHK_TYPED, 32'h1234_5678, 16'd1, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd2,  6'd1,  CHK_TYPED, 32'h0, 16'd1, 1'b0));
        // Reads past the edge of the latest grid give zero.
        dir_steps.push_back(cmd_row(OP_READ, 6'd3,  6'd0,  CHK_TYPED, 32'h0, 16'd1, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd0,  6'd63, CHK_TYPED, 32'h0, 16'd1, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd63, 6'd0,  CHK_TYPED, 32'h0, 16'd1, 1'b0));
        // Size zero acts as one; full-scale borders settle on the second sweep.
        dir_steps.push_back(cfg_row(REG_GRID_SIZE,   32'd0));
        dir_steps.push_back(cfg_row(REG_LEFT_TEMP,   32'hFFFF_FFFF));
        dir_steps.push_back(cfg_row(REG_RIGHT_TEMP,  32'hFFFF_FFFF));
        dir_steps.push_back(cfg_row(REG_BOTTOM_TEMP, 32'hFFFF_FFFF));
        dir_steps.push_back(cfg_row(REG_ITER_LIMIT,  32'd3));
        dir_steps.push_back(cfg_row(REG_MAX_DELTA,   32'd1));
        dir_steps.push_back(cmd_row(OP_RUN,  6'd0,  6'd0,  CHK_TYPED, 32'h0, 16'd2, 1'b1));
        dir_steps.push_back(cmd_row(OP_READ, 6'd1,  6'd1,  CHK_TYPED, 32'hFFFF_FFFF, 16'd2, 1'b1));
        // Oversize grid saturates; widest threshold stops after one sweep.
        dir_steps.push_back(cfg_row(REG_GRID_SIZE,   32'd63));
        dir_steps.push_back(cfg_row(REG_ITER_LIMIT,  32'hFFFF));
        dir_steps.push_back(cfg_row(REG_MAX_DELTA,   32'hFFFF_FFFF));
        dir_steps.push_back(cfg_row(REG_LEFT_TEMP,   32'h7FFF_FFFF));
        dir_steps.push_back(cfg_row(REG_TOP_TEMP,    32'h8000_0000));
        dir_steps.push_back(cfg_row(REG_RIGHT_TEMP,  32'h1));
        dir_steps.push_back(cfg_row(REG_BOTTOM_TEMP, 32'hFFFF_FFFE));
        dir_steps.push_back(cmd_row(OP_RUN,  6'd0,  6'd0,  CHK_TYPED, 32'h0, 16'd1, 1'b1));
        dir_steps.push_back(cmd_row(OP_READ, 6'd63, 6'd63, CHK_TYPED, 32'h1, 16'd1, 1'b1));
        dir_steps.push_back(cmd_row(OP_READ, 6'd1,  6'd1,  CHK_MODEL, 32'h0, 16'd0, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd62, 6'd62, CHK_MODEL, 32'h0, 16'd0, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd0,  6'd32, CHK_TYPED, 32'h8000_0000, 16'd1, 1'b1));
        dir_steps.push_back(cmd_row(OP_READ, 6'd63, 6'd1,  CHK_TYPED, 32'hFFFF_FFFE, 16'd1, 1'b1));
        // Zero threshold never converges: the full limit is run.
        dir_steps.push_back(cfg_row(REG_GRID_SIZE,   32'd2));
        dir_steps.push_back(cfg_row(REG_ITER_LIMIT,  32'd5));
        dir_steps.push_back(cfg_row(REG_MAX_DELTA,   32'd0));
        dir_steps.push_back(cmd_row(OP_RUN,  6'd0,  6'd0,  CHK_TYPED, 32'h0, 16'd5, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd1,  6'd2,  CHK_MODEL, 32'h0, 16'd0, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd2,  6'd1,  CHK_MODEL, 32'h0, 16'd0, 1'b0));
        // Moderate threshold on a small grid.
        dir_steps.push_back(cfg_row(REG_GRID_SIZE,   32'd4));
        dir_steps.push_back(cfg_row(REG_ITER_LIMIT,  32'd200));
        dir_steps.push_back(cfg_row(REG_MAX_DELTA,   32'h100));
        dir_steps.push_back(cmd_row(OP_RUN,  6'd0,  6'd0,  CHK_MODEL, 32'h0, 16'd0, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd3,  6'd3,  CHK_MODEL, 32'h0, 16'd0, 1'b0));
        dir_steps.push_back(cmd_row(OP_READ, 6'd5,  6'd5,  CHK_MODEL, 32'h0, 16'd0, 1'b0));
    end

    // Main sequence.
    initial begin
        int                   i;
        int                   sent;
        int                   count;
        int                   sel;
        logic                 no_idle;
        logic                 op;
        logic [POS_W-1:0]     r;
        logic [POS_W-1:0]     c;
        logic [SIZE_W-1:0]    sz;
        logic [ITER_W-1:0]    lim;
        logic [TEMP_W-1:0]    val;
        logic [REG_IDX_W-1:0] ri;
        t_step_row            st;
        t_heat_word           none;

        none     = '0;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        i_opcode = OP_RUN;
        i_row    = '0;
        i_column = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part.
        for (i = 0; i < dir_steps.size(); i++) begin
            st = dir_steps[i];
            if (st.act == ACT_WRITE) begin
                drain_block();
                apb_write(st.reg_idx, st.value);
            end else begin
                send_cmd(st.op, st.row, st.col, st.chk, st.want, pick_gap(1'b0));
            end
        end

        // Random phases: new settings, a run, then reads and further runs.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = int'($urandom_range(0, 19));
            if (sel < 14) begin
                sz  = SIZE_W'($urandom_range(1, 6));
                lim = ($urandom_range(0, 9) == 0) ? 16'd0 : ITER_W'($urandom_range(1, 60));
            end else if (sel < 17) begin
                sz  = SIZE_W'($urandom_range(7, 16));
                lim = ITER_W'($urandom_range(0, 3));
            end else if (sel == 17) begin
                sz  = 6'd0;
                lim = ITER_W'($urandom_range(1, 200));
            end else begin
                sz  = (sel == 18) ? 6'd63 : 6'd62;
                lim = ITER_W'($urandom_range(0, 1));
            end
            drain_block();
            apb_write(REG_GRID_SIZE, 32'(sz));
            apb_write(REG_ITER_LIMIT, 32'(lim));
            for (ri = REG_LEFT_TEMP; ri <= REG_BOTTOM_TEMP; ri++) begin
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 7))
                        0:       val = 32'h0;
                        1:       val = 32'hFFFF_FFFF;
                        2:       val = $urandom_range(0, 32'h1_0000);
                        default: val = $urandom;
                    endcase
                    apb_write(ri, val);
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       val = 32'h0;
                    1:       val = 32'hFFFF_FFFF;
                    2:       val = $urandom_range(1, 16);
                    3:       val = $urandom_range(1, 32'h10_0000);
                    default: val = $urandom;
                endcase
                apb_write(REG_MAX_DELTA, val);
            end

            no_idle = ($urandom_range(0, 3) == 0);
            count   = int'($urandom_range(3, 10));
            for (i = 0; i < count; i++) begin
                op = (i == 0 || $urandom_range(0, 3) == 0) ? OP_RUN : OP_READ;
                if (op == OP_READ && $urandom_range(0, 4) != 0) begin
                    r = POS_W'($urandom_range(0, run_n + 1));
                    c = POS_W'($urandom_range(0, run_n + 1));
                end else begin
                    r = POS_W'($urandom);
                    c = POS_W'($urandom);
                end
                send_cmd(op, r, c, CHK_MODEL, none, pick_gap(no_idle));
                sent++;
            end
        end

        // Wind down and report.
        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (heat_words_due.size() != 0) begin
            $error("%0d result words never arrived", heat_words_due.size());
            errors += heat_words_due.size();
        end
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
